>>> design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned WIN_DEPTH = 8;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned REG_W     = 64;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QAW       = 2;

	localparam logic [1:0] REG_PATTERN_BYTES = 2'd0;
	localparam logic [1:0] REG_PATTERN_LEN   = 2'd1;
	localparam logic [1:0] REG_SUBST_BYTES   = 2'd2;
	localparam logic [1:0] REG_SUBST_LEN     = 2'd3;

	// One queued job: the bytes caused by one input, oldest in bits 7:0.
	// cnt of zero with last set is the empty end marker.
	typedef struct packed {
		logic [REG_W-1:0] bytes;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} job_t;

endpackage

>>> design/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Config registers, pending window and match check; at most one job per request.
// ----------------------------------------------------------------------------
module sfr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [sfr_pkg::REG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	input  logic                        q_full,
	output logic                        in_ready,
	output logic                        push,
	output sfr_pkg::job_t               job
);

	logic [sfr_pkg::REG_W-1:0] pat_q;
	logic [sfr_pkg::LEN_W-1:0] plen_q;
	logic [sfr_pkg::REG_W-1:0] sub_q;
	logic [sfr_pkg::LEN_W-1:0] slen_q;
	logic [7:0]                win_q [sfr_pkg::WIN_DEPTH];
	logic [sfr_pkg::CNT_W-1:0] cnt_q;

	logic [sfr_pkg::CNT_W-1:0] plen, slen, cnt_c, cnt_inc, cnt_n;
	logic [7:0]                win_w [sfr_pkg::WIN_DEPTH];
	logic [7:0]                win_n [sfr_pkg::WIN_DEPTH];
	logic [sfr_pkg::REG_W-1:0] win_flat;
	logic                      full, hit, accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		plen = (plen_q > 4'd8) ? 4'd8 : plen_q;
		slen = (slen_q > 4'd8) ? 4'd8 : slen_q;
		cnt_c = (cnt_q >= plen && plen != 4'd0) ? plen - 4'd1 : cnt_q;
		cnt_inc = cnt_c + 4'd1;
		full = (cnt_inc == plen);
		hit = 1'b1;
		for (int j = 0; j < sfr_pkg::WIN_DEPTH; j++) begin
			win_w[j] = (cnt_c == 4'(j)) ? in_byte : win_q[j];
			win_flat[j*8 +: 8] = win_w[j];
			if (4'(j) < plen && win_w[j] != pat_q[j*8 +: 8])
				hit = 1'b0;
		end
		for (int j = 0; j < sfr_pkg::WIN_DEPTH; j++) begin
			win_n[j] = (j < sfr_pkg::WIN_DEPTH - 1) ? win_w[(j + 1) % sfr_pkg::WIN_DEPTH]
			                                       : win_w[j];
		end

		job.last  = in_last;
		job.bytes = win_flat;
		job.cnt   = 4'd0;
		cnt_n     = cnt_inc;
		if (plen == 4'd0) begin
			job.bytes = {56'd0, in_byte};
			job.cnt   = 4'd1;
			cnt_n     = 4'd0;
		end else if (full && hit) begin
			job.bytes = sub_q;
			job.cnt   = slen;
			cnt_n     = 4'd0;
		end else if (full) begin
			// miss: oldest byte goes out; on the last input the rest follows
			job.cnt = in_last ? plen : 4'd1;
			cnt_n   = plen - 4'd1;
		end else if (in_last) begin
			job.cnt = cnt_inc;
		end
		if (in_last)
			cnt_n = 4'd0;
		push = accept && (job.cnt != 4'd0 || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= '0;
			sub_q  <= '0;
			slen_q <= '0;
			cnt_q  <= '0;
			for (int j = 0; j < sfr_pkg::WIN_DEPTH; j++)
				win_q[j] <= '0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_n;
				for (int j = 0; j < sfr_pkg::WIN_DEPTH; j++)
					win_q[j] <= (full && !hit) ? win_n[j] : win_w[j];
			end
			if (cfg_we) begin
				case (cfg_index)
					sfr_pkg::REG_PATTERN_BYTES: pat_q <= cfg_data;
					sfr_pkg::REG_PATTERN_LEN: begin
						plen_q <= cfg_data[sfr_pkg::LEN_W-1:0];
						cnt_q  <= '0;
					end
					sfr_pkg::REG_SUBST_BYTES: sub_q <= cfg_data;
					sfr_pkg::REG_SUBST_LEN:   slen_q <= cfg_data[sfr_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

>>> design/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Short job queue between the match front and the emit back.
// ----------------------------------------------------------------------------
module sfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output sfr_pkg::job_t head_job
);

	sfr_pkg::job_t            mem_q [sfr_pkg::QDEPTH];
	logic [sfr_pkg::QAW-1:0]  wr_q, rd_q;
	logic [sfr_pkg::QAW:0]    fill_q;

	assign full       = (fill_q == (sfr_pkg::QAW+1)'(sfr_pkg::QDEPTH));
	assign head_valid = (fill_q != '0);
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> design/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Walks the head job one byte per cycle, while the receiver accepts, into a registered output stage.
// ----------------------------------------------------------------------------
module sfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  sfr_pkg::job_t head_job,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [7:0]    m_axis_tdata,
	output logic          m_axis_tlast,
	output logic [1:0]    m_axis_tuser
);

	logic [sfr_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                byte_q;
	logic                      has_q, run_last_q, done_q;
	logic                      load, run_end;

	assign load    = head_valid && (!out_valid_q || m_axis_tready);
	assign run_end = (head_job.cnt == 4'd0) ||
	                 ({1'b0, idx_q} == head_job.cnt - 4'd1);
	assign pop     = load && run_end;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = byte_q;
	assign m_axis_tlast  = run_last_q;
	assign m_axis_tuser  = {done_q, has_q};

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= (head_job.cnt == 4'd0) ? 8'd0 : head_job.bytes[idx_q*8 +: 8];
			has_q      <= (head_job.cnt != 4'd0);
			run_last_q <= run_end;
			done_q     <= run_end && head_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (pop)
				idx_q <= '0;
			else if (load)
				idx_q <= idx_q + 1'b1;
		end
	end

endmodule

>>> design/stream_find_replace_top.sv
// ----------------------------------------------------------------------------
// stream_find_replace_top
// Streaming find-and-replace of a pattern of up to 8 bytes in a byte stream.
// ----------------------------------------------------------------------------
// Input channel s_axis: one text byte per request, tlast marks the end of text.
// Output channel m_axis: one rewritten byte per request; tlast closes the run
// of results caused by one input byte, tuser[0] says the byte is valid (clear
// only on the empty end marker), tuser[1] marks the final result of the text.
// Config: cfg_we/cfg_index/cfg_data write pattern, its length, replacement and
// its length; write only while the block is idle. Writing the pattern length
// drops pending bytes.
// The first result of an input passes through the queue write, then the output
// register, before it is offered.
// Inputs are taken one per cycle while each input yields at most one result and
// the receiver keeps up; an input yielding several results holds the output until
// all are out, and a four-job queue lets the input side run ahead until it fills.
// Reset clears registers, window and queue; no clearing pass is needed.
// A stalled receiver holds the output register; the queue then fills and
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module stream_find_replace_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [sfr_pkg::REG_W-1:0] cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
	input  logic                      s_axis_tlast,   // stream_end
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
	output logic                      m_axis_tlast,   // run_last
	output logic [1:0]                m_axis_tuser    // [0] has_byte, [1] text_done
);

	logic          q_full, push, head_valid, pop;
	sfr_pkg::job_t push_job, head_job;

	sfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.job       (push_job)
	);

	sfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	sfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
